/* hdl/gradient_histogram_and_split_macros.svh */
// assertion helpers for the rtl files
`ifndef GRADIENT_HISTOGRAM_AND_SPLIT_MACROS_SVH
`define GRADIENT_HISTOGRAM_AND_SPLIT_MACROS_SVH

// same-cycle implication
`define GHS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GHS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/ghs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ghs_pkg;

   localparam int ROWS_DEFAULT = 65536;
   localparam int BINS_DEFAULT = 256;
   localparam int BIN_REACH    = 256;

   localparam int OP_W       = 2;
   localparam int ROW_W      = 16;
   localparam int BIN_W      = 8;
   localparam int GRAD_W     = 32;
   localparam int SUM_W      = 48;
   localparam int CNT_W      = 17;
   localparam int SLOT_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [OP_W-1:0] OP_WRITE_BIN  = 2'd0;
   localparam logic [OP_W-1:0] OP_ACCUMULATE = 2'd1;
   localparam logic [OP_W-1:0] OP_CLASSIFY   = 2'd2;
   localparam logic [OP_W-1:0] OP_READ_CLEAR = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_LOW_BIN        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_BIN       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_OFFSET = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPLIT_THRESH   = 2'd3;

   localparam logic [CNT_W-1:0] CNT_MAX   = 17'h1FFFF;
   localparam logic [CNT_W-1:0] BATCH_MAX = 17'h10000;

   typedef struct packed {
      logic [OP_W-1:0]          opcode;
      logic [ROW_W-1:0]         row_index;
      logic [BIN_W-1:0]         bin_value;
      logic signed [GRAD_W-1:0] gradient;
      logic [BIN_W-1:0]         hist_index;
      logic                     last_of_batch;
   } req_payload_type;

   typedef struct packed {
      logic                    goes_greater;
      logic [SLOT_W-1:0]       slot;
      logic [CNT_W-1:0]        lte_total;
      logic signed [SUM_W-1:0] sum_out;
      logic [CNT_W-1:0]        count_out;
   } rsp_payload_type;

   typedef struct packed {
      logic [BIN_W-1:0] low_bin;
      logic [BIN_W-1:0] high_bin;
      logic [BIN_W-1:0] default_bin_offset;
      logic [BIN_W-1:0] split_threshold;
   } cfg_type;

   typedef struct packed {
      logic [CNT_W-1:0]        count;
      logic signed [SUM_W-1:0] sum;
   } hist_entry_type;

endpackage

`default_nettype wire

/* hdl/ghs_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface ghs_req_if;
   logic                     valid;
   logic                     ready;
   ghs_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ghs_rsp_if;
   logic                     valid;
   logic                     ready;
   ghs_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hdl/ghs_classify.sv */
`timescale 1ns / 1ps
`default_nettype none

module ghs_classify (
   input  wire logic [ghs_pkg::BIN_W-1:0] bin,
   input  wire ghs_pkg::cfg_type          cfg,
   output logic                           goes_greater
);

   logic              dflt_zero;
   logic signed [9:0] bin_s;
   logic signed [9:0] th_s;
   logic signed [9:0] dflt_s;

   always_comb begin
      dflt_zero = (cfg.default_bin_offset == '0);
      bin_s     = $signed({2'b00, bin});
      th_s      = $signed({2'b00, cfg.low_bin}) + $signed({2'b00, cfg.split_threshold})
                  - $signed({9'd0, dflt_zero});
      dflt_s    = $signed({2'b00, cfg.low_bin}) + $signed({2'b00, cfg.default_bin_offset})
                  - $signed({9'd0, dflt_zero});
      goes_greater = (bin < cfg.low_bin) || (bin > cfg.high_bin)
                     || (bin_s == dflt_s) || (bin_s > th_s);
   end

endmodule

`default_nettype wire

/* hdl/gradient_histogram_and_split.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "gradient_histogram_and_split_macros.svh"

// Gradient histogram and split unit. Row bins sit in a ROWS-deep memory and the
// histogram (sum and count per bin) in a second memory, both with registered
// reads. One request is worked at a time: write-bin, classify and read-clear
// finish in the lookup state, accumulate in the update state after it (bin
// lookup, then histogram read with saturating add and write back; a bin beyond
// the histogram ends in lookup), and the next request is taken in the cycle the
// result appears. A new request is taken while the previous result still
// waits on rsp_chan; the one after that holds the unit until the waiting
// result leaves. After reset the histogram is cleared one entry per cycle,
// all min(BINS,256) entries, before the first request is taken; csr writes
// are taken throughout.

module gradient_histogram_and_split #(
   parameter int ROWS = ghs_pkg::ROWS_DEFAULT,
   parameter int BINS = ghs_pkg::BINS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   ghs_req_if.sink                              req_chan,
   ghs_rsp_if.source                            rsp_chan,
   input  wire logic                            csr_we,
   input  wire logic [ghs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ghs_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int HIST_DEPTH = (BINS < ghs_pkg::BIN_REACH) ? BINS : ghs_pkg::BIN_REACH;
   localparam int HIST_AW    = $clog2(HIST_DEPTH);
   localparam int ROW_AW     = $clog2(ROWS);
   localparam logic [HIST_AW-1:0] HIST_LAST = HIST_AW'(HIST_DEPTH - 1);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_LOOKUP  = 2'd1;
   localparam logic [1:0] ST_UPDATE  = 2'd2;
   localparam logic [1:0] ST_DELIVER = 2'd3;

   logic [1:0]                       state_ff, state_in;
   logic                             clr_ff, clr_in;
   logic [HIST_AW-1:0]               clr_addr_ff, clr_addr_in;
   ghs_pkg::cfg_type                 cfg_ff, cfg_in;
   ghs_pkg::req_payload_type         cur_ff, cur_in;
   logic                             row_ok_ff, row_ok_in;
   logic [ghs_pkg::CNT_W-1:0]        lte_ff, lte_in;
   logic [ghs_pkg::CNT_W-1:0]        gt_ff, gt_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   ghs_pkg::rsp_payload_type         rsp_data_ff, rsp_data_in;
   ghs_pkg::rsp_payload_type         pend_ff, pend_in;

   logic                             req_fire;
   logic                             out_free;
   logic [31:0]                      row_wide;
   logic                             row_ok_now;
   logic [ROW_AW-1:0]                row_addr;

   logic [ghs_pkg::BIN_W-1:0]        row_mem [ROWS];
   logic [ghs_pkg::BIN_W-1:0]        row_rdata_ff;
   logic [ghs_pkg::BIN_W-1:0]        bin_eff;
   logic                             bin_in_hist;
   logic                             hidx_ok;

   ghs_pkg::hist_entry_type          hist_mem [HIST_DEPTH];
   ghs_pkg::hist_entry_type          hist_rdata_ff;
   logic [HIST_AW-1:0]               hist_raddr;
   logic                             hist_we;
   logic [HIST_AW-1:0]               hist_waddr;
   ghs_pkg::hist_entry_type          hist_wdata;

   logic                             greater;
   logic                             done;
   ghs_pkg::rsp_payload_type         res_now;
   logic [ghs_pkg::CNT_W-1:0]        lte_upd;
   logic [ghs_pkg::CNT_W-1:0]        gt_upd;
   logic signed [ghs_pkg::SUM_W:0]   sum_wide;
   logic signed [ghs_pkg::SUM_W-1:0] sum_sat;

   assign req_chan.ready   = (state_ff == ST_IDLE) && !clr_ff;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   assign req_fire   = req_chan.valid && req_chan.ready;
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign row_wide   = 32'(req_chan.payload.row_index);
   assign row_ok_now = row_wide < 32'(ROWS);
   assign row_addr   = row_wide[ROW_AW-1:0];

   assign bin_eff     = row_ok_ff ? row_rdata_ff : '0;
   assign bin_in_hist = 32'(bin_eff) < 32'(BINS);
   assign hidx_ok     = 32'(cur_ff.hist_index) < 32'(BINS);
   assign hist_raddr  = (state_ff == ST_IDLE) ? req_chan.payload.hist_index[HIST_AW-1:0]
                                              : bin_eff[HIST_AW-1:0];

   ghs_classify u_classify (
      .bin          (bin_eff),
      .cfg          (cfg_ff),
      .goes_greater (greater)
   );

   // row bin store
   always_ff @(posedge clock) begin
      if (req_fire) begin
         if (req_chan.payload.opcode == ghs_pkg::OP_WRITE_BIN && row_ok_now) begin
            row_mem[row_addr] <= req_chan.payload.bin_value;
         end
         row_rdata_ff <= row_mem[row_addr];
      end
   end

   // histogram store
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      hist_rdata_ff <= hist_mem[hist_raddr];
   end

   always_comb begin
      lte_upd = lte_ff;
      gt_upd  = gt_ff;
      if (greater && gt_ff != ghs_pkg::BATCH_MAX) begin
         gt_upd = gt_ff + 1'b1;
      end
      if (!greater && lte_ff != ghs_pkg::BATCH_MAX) begin
         lte_upd = lte_ff + 1'b1;
      end

      sum_wide = {hist_rdata_ff.sum[ghs_pkg::SUM_W-1], hist_rdata_ff.sum}
                 + {{(ghs_pkg::SUM_W + 1 - ghs_pkg::GRAD_W){cur_ff.gradient[ghs_pkg::GRAD_W-1]}},
                    cur_ff.gradient};
      if (sum_wide[ghs_pkg::SUM_W] != sum_wide[ghs_pkg::SUM_W-1]) begin
         sum_sat = sum_wide[ghs_pkg::SUM_W] ? {1'b1, {(ghs_pkg::SUM_W-1){1'b0}}}
                                            : {1'b0, {(ghs_pkg::SUM_W-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[ghs_pkg::SUM_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      clr_addr_in  = clr_addr_ff;
      cfg_in       = cfg_ff;
      cur_in       = cur_ff;
      row_ok_in    = row_ok_ff;
      lte_in       = lte_ff;
      gt_in        = gt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      pend_in      = pend_ff;
      hist_we      = 1'b0;
      hist_waddr   = clr_addr_ff;
      hist_wdata   = '0;
      res_now      = '0;
      done         = 1'b0;

      if (clr_ff) begin
         hist_we     = 1'b1;
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == HIST_LAST) begin
            clr_in = 1'b0;
         end
      end

      if (csr_we) begin
         case (csr_index)
            ghs_pkg::CSR_LOW_BIN:        cfg_in.low_bin            = csr_wdata;
            ghs_pkg::CSR_HIGH_BIN:       cfg_in.high_bin           = csr_wdata;
            ghs_pkg::CSR_DEFAULT_OFFSET: cfg_in.default_bin_offset = csr_wdata;
            ghs_pkg::CSR_SPLIT_THRESH:   cfg_in.split_threshold    = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cur_in    = req_chan.payload;
               row_ok_in = row_ok_now;
               state_in  = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            case (cur_ff.opcode)
               ghs_pkg::OP_ACCUMULATE: begin
                  if (bin_in_hist) begin
                     state_in = ST_UPDATE;
                  end else begin
                     done = 1'b1;
                  end
               end
               ghs_pkg::OP_CLASSIFY: begin
                  done                 = 1'b1;
                  res_now.goes_greater = greater;
                  if (greater) begin
                     res_now.slot = gt_ff[ghs_pkg::CNT_W-1] ? '1 : gt_ff[ghs_pkg::SLOT_W-1:0];
                  end else begin
                     res_now.slot = lte_ff[ghs_pkg::CNT_W-1] ? '1 : lte_ff[ghs_pkg::SLOT_W-1:0];
                  end
                  res_now.lte_total = lte_upd;
                  lte_in = cur_ff.last_of_batch ? '0 : lte_upd;
                  gt_in  = cur_ff.last_of_batch ? '0 : gt_upd;
               end
               ghs_pkg::OP_READ_CLEAR: begin
                  done = 1'b1;
                  if (hidx_ok) begin
                     res_now.sum_out   = hist_rdata_ff.sum;
                     res_now.count_out = hist_rdata_ff.count;
                     hist_we           = 1'b1;
                     hist_waddr        = cur_ff.hist_index[HIST_AW-1:0];
                  end
               end
               default: begin
                  done = 1'b1;
               end
            endcase
         end
         ST_UPDATE: begin
            done             = 1'b1;
            hist_we          = 1'b1;
            hist_waddr       = bin_eff[HIST_AW-1:0];
            hist_wdata.sum   = sum_sat;
            hist_wdata.count = (hist_rdata_ff.count != ghs_pkg::CNT_MAX)
                               ? hist_rdata_ff.count + 1'b1 : hist_rdata_ff.count;
         end
         ST_DELIVER: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (done) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = res_now;
            state_in     = ST_IDLE;
         end else begin
            pend_in  = res_now;
            state_in = ST_DELIVER;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff                  <= ST_IDLE;
         clr_ff                    <= 1'b1;
         clr_addr_ff               <= '0;
         cfg_ff.low_bin            <= '0;
         cfg_ff.high_bin           <= '1;
         cfg_ff.default_bin_offset <= '0;
         cfg_ff.split_threshold    <= '0;
         lte_ff                    <= '0;
         gt_ff                     <= '0;
         rsp_valid_ff              <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_addr_ff  <= clr_addr_in;
         cfg_ff       <= cfg_in;
         lte_ff       <= lte_in;
         gt_ff        <= gt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      row_ok_ff   <= row_ok_in;
      rsp_data_ff <= rsp_data_in;
      pend_ff     <= pend_in;
   end

   `GHS_ASSERT_IMPLY(clear_only_when_idle, clock, reset, clr_ff, state_ff == ST_IDLE, "histogram clear overlaps a request")
   `GHS_ASSERT_IMPLY(deliver_has_full_output, clock, reset, state_ff == ST_DELIVER, rsp_valid_ff, "pending result without a held output")
   `GHS_ASSERT_IMPLY(batch_counters_bounded, clock, reset, 1'b1, (lte_ff <= ghs_pkg::BATCH_MAX) && (gt_ff <= ghs_pkg::BATCH_MAX), "batch counter beyond its limit")
   `GHS_ASSERT_NEXT(update_only_for_accumulate, clock, reset, (state_ff == ST_LOOKUP) && (cur_ff.opcode != ghs_pkg::OP_ACCUMULATE), state_ff != ST_UPDATE, "histogram update for a non-accumulate request")

endmodule

`default_nettype wire

/* verif/tb_gradient_histogram_and_split.sv */
`timescale 1ns / 1ps

module tb_gradient_histogram_and_split;

   localparam int     MAX_WAIT = 19;
   localparam longint SUM_HI   = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint SUM_LO   = -SUM_HI - 1;

   logic                           clock;
   logic                           reset;
   logic                           csr_we;
   logic [ghs_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [ghs_pkg::CSR_DATA_W-1:0] csr_wdata;

   ghs_req_if req_chan ();
   ghs_rsp_if rsp_chan ();

   gradient_histogram_and_split dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   ghs_pkg::cfg_type                 cur_cfg;
   logic [ghs_pkg::BIN_W-1:0]        row_bin [int];
   logic signed [ghs_pkg::SUM_W-1:0] hist_sum [ghs_pkg::BINS_DEFAULT];
   logic [ghs_pkg::CNT_W-1:0]        hist_count [ghs_pkg::BINS_DEFAULT];
   logic [ghs_pkg::CNT_W-1:0]        lte_rows;
   logic [ghs_pkg::CNT_W-1:0]        gt_rows;

   ghs_pkg::req_payload_type req_backlog [$];
   ghs_pkg::rsp_payload_type awaited_rsp [$];

   // rows the stimulus has posted writes to so far
   int                        known_rows [$];
   logic [ghs_pkg::BIN_W-1:0] planned_bin [int];

   bit failed;
   bit idle_on;
   int send_gap;
   int recv_stall;

   function automatic ghs_pkg::rsp_payload_type compute_response(ghs_pkg::req_payload_type r);
      ghs_pkg::rsp_payload_type res;
      longint                   total;
      int                       b;
      int                       lo;
      int                       hi;
      int                       th;
      int                       dflt;
      bit                       greater;
      res = '0;
      case (r.opcode)
         ghs_pkg::OP_WRITE_BIN: begin
            row_bin[int'(r.row_index)] = r.bin_value;
         end
         ghs_pkg::OP_ACCUMULATE: begin
            b = int'(row_bin[int'(r.row_index)]);
            total = longint'($signed(hist_sum[b])) + longint'(r.gradient);
            if (total > SUM_HI) begin
               total = SUM_HI;
            end else if (total < SUM_LO) begin
               total = SUM_LO;
            end
            hist_sum[b] = total[ghs_pkg::SUM_W-1:0];
            if (hist_count[b] != ghs_pkg::CNT_MAX) begin
               hist_count[b] = hist_count[b] + 1'b1;
            end
         end
         ghs_pkg::OP_CLASSIFY: begin
            b = int'(row_bin[int'(r.row_index)]);
            lo = int'(cur_cfg.low_bin);
            hi = int'(cur_cfg.high_bin);
            th = lo + int'(cur_cfg.split_threshold);
            dflt = lo + int'(cur_cfg.default_bin_offset);
            if (cur_cfg.default_bin_offset == 0) begin
               th = th - 1;
               dflt = dflt - 1;
            end
            greater = (b < lo) || (b > hi) || (b == dflt) || (b > th);
            res.goes_greater = greater;
            if (greater) begin
               res.slot = (gt_rows > 17'd65535) ? 16'hFFFF : gt_rows[ghs_pkg::SLOT_W-1:0];
               if (gt_rows < ghs_pkg::BATCH_MAX) begin
                  gt_rows = gt_rows + 1'b1;
               end
            end else begin
               res.slot = (lte_rows > 17'd65535) ? 16'hFFFF : lte_rows[ghs_pkg::SLOT_W-1:0];
               if (lte_rows < ghs_pkg::BATCH_MAX) begin
                  lte_rows = lte_rows + 1'b1;
               end
            end
            res.lte_total = lte_rows;
            if (r.last_of_batch) begin
               lte_rows = '0;
               gt_rows = '0;
            end
         end
         ghs_pkg::OP_READ_CLEAR: begin
            res.sum_out = hist_sum[r.hist_index];
            res.count_out = hist_count[r.hist_index];
            hist_sum[r.hist_index] = '0;
            hist_count[r.hist_index] = '0;
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         failed = 1'b1;
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   function automatic void post_request(ghs_pkg::req_payload_type r);
      if (r.opcode == ghs_pkg::OP_WRITE_BIN) begin
         if (!planned_bin.exists(int'(r.row_index))) begin
            known_rows.insert(known_rows.size(), int'(r.row_index));
         end
         planned_bin[int'(r.row_index)] = r.bin_value;
      end
      req_backlog.insert(req_backlog.size(), r);
   endfunction

   function automatic void post(logic [ghs_pkg::OP_W-1:0] op, logic [ghs_pkg::ROW_W-1:0] row,
                                logic [ghs_pkg::BIN_W-1:0] binv,
                                logic [ghs_pkg::GRAD_W-1:0] grad,
                                logic [ghs_pkg::BIN_W-1:0] hidx, logic last);
      ghs_pkg::req_payload_type r;
      r.opcode = op;
      r.row_index = row;
      r.bin_value = binv;
      r.gradient = grad;
      r.hist_index = hidx;
      r.last_of_batch = last;
      post_request(r);
   endfunction

   function automatic int pick_known_row();
      return known_rows[$urandom_range(0, known_rows.size() - 1)];
   endfunction

   // bins at the borders of the current split window
   function automatic logic [ghs_pkg::BIN_W-1:0] border_bin();
      int lo;
      int th;
      int dflt;
      int cand;
      lo = int'(cur_cfg.low_bin);
      th = lo + int'(cur_cfg.split_threshold);
      dflt = lo + int'(cur_cfg.default_bin_offset);
      if (cur_cfg.default_bin_offset == 0) begin
         th = th - 1;
         dflt = dflt - 1;
      end
      case ($urandom_range(0, 6))
         0: cand = lo - 1;
         1: cand = lo;
         2: cand = int'(cur_cfg.high_bin);
         3: cand = int'(cur_cfg.high_bin) + 1;
         4: cand = th;
         5: cand = th + 1;
         default: cand = dflt;
      endcase
      if (cand < 0) begin
         cand = 0;
      end
      if (cand > 255) begin
         cand = 255;
      end
      return cand[ghs_pkg::BIN_W-1:0];
   endfunction

   function automatic ghs_pkg::req_payload_type random_request();
      ghs_pkg::req_payload_type r;
      int                       pick;
      r.row_index = 16'($urandom);
      r.bin_value = 8'($urandom);
      r.gradient = $urandom;
      r.hist_index = 8'($urandom);
      r.last_of_batch = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         r.opcode = ghs_pkg::OP_WRITE_BIN;
         if ($urandom_range(0, 2) == 0) begin
            r.row_index = 16'(pick_known_row());
         end
         if ($urandom_range(0, 1) == 0) begin
            r.bin_value = border_bin();
         end
      end else if (pick < 50) begin
         r.opcode = ghs_pkg::OP_ACCUMULATE;
         r.row_index = 16'(pick_known_row());
         case ($urandom_range(0, 7))
            0: r.gradient = 32'h7FFF_FFFF;
            1: r.gradient = 32'h8000_0000;
            2: r.gradient = $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
            default: ;
         endcase
      end else if (pick < 85) begin
         r.opcode = ghs_pkg::OP_CLASSIFY;
         r.row_index = 16'(pick_known_row());
         r.last_of_batch = ($urandom_range(0, 9) == 0);
      end else begin
         r.opcode = ghs_pkg::OP_READ_CLEAR;
         if ($urandom_range(0, 1) == 0) begin
            r.hist_index = planned_bin[pick_known_row()];
         end
      end
      return r;
   endfunction

   task automatic write_register(logic [ghs_pkg::CSR_IDX_W-1:0] idx,
                                 logic [ghs_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         ghs_pkg::CSR_LOW_BIN:        cur_cfg.low_bin = value;
         ghs_pkg::CSR_HIGH_BIN:       cur_cfg.high_bin = value;
         ghs_pkg::CSR_DEFAULT_OFFSET: cur_cfg.default_bin_offset = value;
         ghs_pkg::CSR_SPLIT_THRESH:   cur_cfg.split_threshold = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_window(logic [7:0] lo, logic [7:0] hi, logic [7:0] off, logic [7:0] thr);
      write_register(ghs_pkg::CSR_LOW_BIN, lo);
      write_register(ghs_pkg::CSR_HIGH_BIN, hi);
      write_register(ghs_pkg::CSR_DEFAULT_OFFSET, off);
      write_register(ghs_pkg::CSR_SPLIT_THRESH, thr);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_chan.valid || awaited_rsp.size() != 0);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap = 0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid) begin
            awaited_rsp.insert(awaited_rsp.size(), compute_response(req_chan.payload));
            send_gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
         end
         if (send_gap > 0) begin
            send_gap--;
            req_chan.valid <= 1'b0;
         end else if (req_backlog.size() != 0) begin
            req_chan.payload <= req_backlog.pop_front();
            req_chan.valid <= 1'b1;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      ghs_pkg::rsp_payload_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (awaited_rsp.size() == 0) begin
               failed = 1'b1;
               $display("%0t: no response awaited, expected none, got %h", $time,
                        rsp_chan.payload);
            end else begin
               want = awaited_rsp.pop_front();
               compare_field("goes_greater", 64'(want.goes_greater),
                             64'(rsp_chan.payload.goes_greater));
               compare_field("slot", 64'(want.slot), 64'(rsp_chan.payload.slot));
               compare_field("lte_total", 64'(want.lte_total),
                             64'(rsp_chan.payload.lte_total));
               compare_field("sum_out", 64'(want.sum_out), 64'(rsp_chan.payload.sum_out));
               compare_field("count_out", 64'(want.count_out),
                             64'(rsp_chan.payload.count_out));
            end
            recv_stall = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
         end else if (recv_stall > 0) begin
            recv_stall--;
         end
         rsp_chan.ready <= (recv_stall == 0);
      end
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready = 1'b0;
      failed = 1'b0;
      idle_on = 1'b1;
      cur_cfg.low_bin = 8'd0;
      cur_cfg.high_bin = 8'd255;
      cur_cfg.default_bin_offset = 8'd0;
      cur_cfg.split_threshold = 8'd0;
      for (int i = 0; i < ghs_pkg::BINS_DEFAULT; i++) begin
         hist_sum[i] = '0;
         hist_count[i] = '0;
      end
      lte_rows = '0;
      gt_rows = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset window: every row lands on the greater side
      post(ghs_pkg::OP_WRITE_BIN, 16'h0000, 8'h00, 32'h0, 8'h00, 1'b0);
      post(ghs_pkg::OP_WRITE_BIN, 16'hFFFF, 8'hFF, 32'h0, 8'h00, 1'b0);
      post(ghs_pkg::OP_WRITE_BIN, 16'h5AA5, 8'h80, 32'h0, 8'h00, 1'b0);
      post(ghs_pkg::OP_ACCUMULATE, 16'h0000, 8'h00, 32'h7FFF_FFFF, 8'h00, 1'b0);
      post(ghs_pkg::OP_ACCUMULATE, 16'h0000, 8'h00, 32'h8000_0000, 8'h00, 1'b0);
      post(ghs_pkg::OP_ACCUMULATE, 16'hFFFF, 8'h00, 32'hFFFF_FFFF, 8'h00, 1'b0);
      post(ghs_pkg::OP_ACCUMULATE, 16'h5AA5, 8'h00, 32'h0001_0000, 8'h00, 1'b0);
      post(ghs_pkg::OP_CLASSIFY, 16'h0000, 8'h00, 32'h0, 8'h00, 1'b0);
      post(ghs_pkg::OP_CLASSIFY, 16'hFFFF, 8'h00, 32'h0, 8'h00, 1'b1);
      post(ghs_pkg::OP_READ_CLEAR, 16'h0000, 8'h00, 32'h0, 8'h00, 1'b0);
      post(ghs_pkg::OP_READ_CLEAR, 16'h0000, 8'h00, 32'h0, 8'hFF, 1'b1);
      post(ghs_pkg::OP_READ_CLEAR, 16'h0000, 8'h00, 32'h0, 8'h80, 1'b0);
      post(ghs_pkg::OP_READ_CLEAR, 16'h0000, 8'h00, 32'h0, 8'h01, 1'b0);
      wait_idle();

      // window 10..200, threshold 60, default 15
      set_window(8'd10, 8'd200, 8'd5, 8'd50);
      post(ghs_pkg::OP_WRITE_BIN, 16'd1, 8'd9, 32'h0, 8'h00, 1'b0);
      post(ghs_pkg::OP_WRITE_BIN, 16'd2, 8'd10, 32'h0, 8'h00, 1'b0);
      post(ghs_pkg::OP_WRITE_BIN, 16'd3, 8'd15, 32'h0, 8'h00, 1'b0);
      post(ghs_pkg::OP_WRITE_BIN, 16'd4, 8'd60, 32'h0, 8'h00, 1'b0);
      post(ghs_pkg::OP_WRITE_BIN, 16'd5, 8'd61, 32'h0, 8'h00, 1'b0);
      post(ghs_pkg::OP_WRITE_BIN, 16'd6, 8'd201, 32'h0, 8'h00, 1'b0);
      for (int i = 1; i <= 6; i++) begin
         post(ghs_pkg::OP_CLASSIFY, i[ghs_pkg::ROW_W-1:0], 8'h00, 32'h0, 8'h00, i == 6);
      end
      wait_idle();

      // back to back without idling
      idle_on = 1'b0;
      set_window(8'd0, 8'd255, 8'd1, 8'd255);
      for (int i = 0; i < 24; i++) begin
         post(ghs_pkg::OP_CLASSIFY, 16'h0000, 8'h00, 32'h0, 8'h00, i == 23);
      end
      for (int i = 0; i < 12; i++) begin
         post(ghs_pkg::OP_ACCUMULATE, 16'h0000, 8'h00, 32'h7FFF_FFFF, 8'h00, 1'b0);
      end
      post(ghs_pkg::OP_READ_CLEAR, 16'h0000, 8'h00, 32'h0, 8'h00, 1'b0);
      for (int i = 0; i < 6; i++) begin
         post(ghs_pkg::OP_ACCUMULATE, 16'hFFFF, 8'h00, 32'h8000_0000, 8'h00, 1'b0);
      end
      post(ghs_pkg::OP_READ_CLEAR, 16'h0000, 8'h00, 32'h0, 8'hFF, 1'b0);
      wait_idle();

      for (int phase = 0; phase < 8; phase++) begin
         idle_on = (phase != 3);
         case (phase)
            0: set_window(8'd0, 8'd255, 8'd0, 8'd0);
            1: set_window(8'd255, 8'd255, 8'd255, 8'd255);
            2: set_window(8'd200, 8'd50, 8'd0, 8'd3);
            3: set_window(8'd16, 8'd240, 8'd8, 8'd100);
            default: set_window(8'($urandom), 8'($urandom),
                                ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom),
                                8'($urandom));
         endcase
         for (int half = 0; half < 2; half++) begin
            for (int i = 0; i < 75; i++) begin
               post_request(random_request());
            end
            wait_idle();
         end
      end

      repeat (20) @(posedge clock);
      if (!failed && awaited_rsp.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
